// ===== rtl/core/sac_pkg.sv =====
// Shared constants, codes and types of the set-associative write-back cache.
package sac_pkg;

    // Default geometry limits
    localparam int DEF_MAX_WAYS        = 8;
    localparam int DEF_MAX_SETS        = 64;
    localparam int DEF_MAX_BLOCK_BYTES = 64;
    localparam int DEF_ADDR_BITS       = 16;
    localparam int DEF_ACCESS_BYTES    = 8;

    // Fixed field widths
    localparam int SIZE_W     = 4;
    localparam int DATA_BYTES = 8;
    localparam int DATA_W     = 64;
    localparam int WAYS_CFG_W = 4;
    localparam int GEO_CFG_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Register reset values
    localparam logic [WAYS_CFG_W-1:0] RST_WAYS_IN_USE = 4'd8;
    localparam logic [GEO_CFG_W-1:0]  RST_OFFSET_BITS = 3'd4;
    localparam logic [GEO_CFG_W-1:0]  RST_SET_BITS    = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAYS_IN_USE = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_SET_BITS    = 2'd2
    } cfg_idx_t;

    localparam logic REQ_STORE = 1'b1;

    // Result word layout
    localparam int M_DATA_W     = 72;
    localparam int OUT_HIT_BIT  = 0;
    localparam int OUT_LOAD_LSB = 1;
    localparam int OUT_WB_BIT   = 65;

    // Shared compare unit result
    typedef struct packed {
        logic tag_eq;
        logic rank_gt;
        logic rank_lt;
    } sac_cmp_t;

endpackage

// ===== rtl/core/set_assoc_writeback_lru_cache.sv =====
// Each word passes decode, metadata read, way search and LRU update, then the byte access; a miss
// adds a byte-by-byte block fill, preceded by a byte-by-byte write-back when the victim is dirty.
// Throughput: one word at a time; s_tready is high only while the sequencer is idle.
// The result register lets the next word enter while the last result waits on m_tready.
// Reset (aresetn low, synchronous) starts a clearing pass over all 2**ADDR_BITS addresses (65536 at
// default) that zeroes backing memory and all line state; no word is accepted until it ends.
module set_assoc_writeback_lru_cache
    import sac_pkg::*;
#(
    parameter int MAX_WAYS        = DEF_MAX_WAYS,
    parameter int MAX_SETS        = DEF_MAX_SETS,
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
    parameter int ADDR_BITS       = DEF_ADDR_BITS,
    parameter int ACCESS_BYTES    = DEF_ACCESS_BYTES,
    localparam int S_DATA_W       = ((ADDR_BITS + SIZE_W + DATA_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // address, access_size, store_data, zero pad
    input  logic                  s_tuser,  // req_type (0 load, 1 store)
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata   // hit, load_data, wrote_back, zero pad
);

    localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W     = $clog2(MAX_WAYS + 1);
    localparam int RANK_W     = WAY_W;
    localparam int SET_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SB_MAX     = $clog2(MAX_SETS);
    localparam int OB_MAX     = $clog2(MAX_BLOCK_BYTES);
    localparam int OFF_W      = OB_MAX;
    localparam int SZ_W       = OFF_W + 2;
    localparam int GEO_W      = $clog2(ADDR_BITS + 1);
    localparam int TAG_W      = ADDR_BITS;
    localparam int META_W     = 2 + TAG_W + RANK_W;
    localparam int ROW_W      = MAX_WAYS * META_W;
    localparam int LINE_AW    = SET_W + WAY_W + OFF_W;
    localparam int LINE_DEPTH = 1 << LINE_AW;
    localparam int META_DEPTH = 1 << SET_W;
    localparam int MEM_DEPTH  = 1 << ADDR_BITS;
    localparam int NB_W       = 4;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_META_RD, S_META_LD, S_SEARCH,
        S_WB_RD, S_WB_WR, S_FILL_RD, S_FILL_WR, S_TOUCH, S_ACC, S_ACC_CAP,
        S_META_WR, S_RESP
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [WAYS_CFG_W-1:0] cfg_ways_reg;
    logic [GEO_CFG_W-1:0]  cfg_ob_reg;
    logic [GEO_CFG_W-1:0]  cfg_sb_reg;

    // request registers
    logic                 store_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [DATA_W-1:0]    sdata_reg;

    // decoded geometry
    logic [GEO_W-1:0]     ob_reg, sb_reg;
    logic [OFF_W-1:0]     off_reg, blk_last_reg;
    logic [SET_W-1:0]     set_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [NB_W-1:0]      nbytes_reg;
    logic [ADDR_BITS-1:0] base_reg, vbase_reg;
    logic [WAY_W-1:0]     ways_last_reg;

    // metadata row of the addressed set
    logic              valid_reg [MAX_WAYS];
    logic              dirty_reg [MAX_WAYS];
    logic [TAG_W-1:0]  tagrow_reg [MAX_WAYS];
    logic [RANK_W-1:0] rank_reg [MAX_WAYS];

    // way search trackers
    logic [WAY_W-1:0]  way_cnt_reg, way_reg, victim_reg;
    logic              empty_found_reg, best_set_reg, vdirty_reg, was_valid_reg;
    logic [RANK_W-1:0] best_reg, vrank_reg, old_rank_reg;
    logic [TAG_W-1:0]  vtag_reg;

    logic [OFF_W-1:0]     byte_cnt_reg;
    logic [NB_W-1:0]      acc_cnt_reg;
    logic [ADDR_BITS-1:0] clr_cnt_reg;
    logic                 hit_reg, wb_reg;
    logic [DATA_W-1:0]    ld_reg;

    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------- decode
    logic [GEO_W-1:0]     ob_c, sb_c, sb_lim_c, sb_cfg_c;
    logic [ADDR_BITS-1:0] blk_mask_c, off_full_c, set_full_c, tag_c;
    logic [SZ_W-1:0]      blk_c, size1_c, sum_c, size2_c;
    logic [NB_W-1:0]      nbytes_c;
    logic [WCNT_W-1:0]    ways_eff_c;
    logic [OFF_W-1:0]     blk_last_c;

    always_comb begin
        ob_c = (GEO_W'(cfg_ob_reg) > GEO_W'(OB_MAX)) ? GEO_W'(OB_MAX) : GEO_W'(cfg_ob_reg);
        sb_lim_c = GEO_W'(ADDR_BITS) - ob_c;
        sb_cfg_c = (GEO_W'(cfg_sb_reg) > GEO_W'(SB_MAX)) ? GEO_W'(SB_MAX) : GEO_W'(cfg_sb_reg);
        sb_c = (sb_cfg_c > sb_lim_c) ? sb_lim_c : sb_cfg_c;
        blk_mask_c = ~({ADDR_BITS{1'b1}} << ob_c);
        off_full_c = addr_reg & blk_mask_c;
        set_full_c = (addr_reg >> ob_c) & ~({ADDR_BITS{1'b1}} << sb_c);
        tag_c = addr_reg >> (ob_c + sb_c);
        blk_c = SZ_W'(1) << ob_c;
        blk_last_c = OFF_W'(blk_c - SZ_W'(1));
        // clamp size to the access limit, then to the block end, then to the 8 reported bytes
        size1_c = (SZ_W'(size_reg) > SZ_W'(ACCESS_BYTES)) ? SZ_W'(ACCESS_BYTES)
                                                          : SZ_W'(size_reg);
        sum_c = SZ_W'(off_full_c[OFF_W-1:0]) + size1_c;
        size2_c = (sum_c > blk_c) ? (blk_c - SZ_W'(off_full_c[OFF_W-1:0])) : size1_c;
        nbytes_c = (size2_c > SZ_W'(DATA_BYTES)) ? NB_W'(DATA_BYTES) : NB_W'(size2_c);
        if (cfg_ways_reg == '0) begin
            ways_eff_c = WCNT_W'(1);
        end else if (WCNT_W'(cfg_ways_reg) > WCNT_W'(MAX_WAYS)) begin
            ways_eff_c = WCNT_W'(MAX_WAYS);
        end else begin
            ways_eff_c = WCNT_W'(cfg_ways_reg);
        end
    end

    // ---------------------------------------------------------------- shared compare unit
    sac_cmp_t          cmp;
    logic [RANK_W-1:0] cmp_b_rank;

    assign cmp_b_rank = (state_reg == S_TOUCH) ? old_rank_reg : best_reg;

    sac_way_cmp #(.TAG_W(TAG_W), .RANK_W(RANK_W)) u_cmp (
        .a_tag  (tagrow_reg[way_cnt_reg]),
        .b_tag  (tag_reg),
        .a_rank (rank_reg[way_cnt_reg]),
        .b_rank (cmp_b_rank),
        .res    (cmp)
    );

    // search step on the current way
    logic              match_j, empty_j, take_j, sel_j, last_j, empty_f, vdirty_f;
    logic [WAY_W-1:0]  victim_f;
    logic [TAG_W-1:0]  vtag_f;
    logic [RANK_W-1:0] vrank_f;
    logic [ADDR_BITS-1:0] vbase_c;

    always_comb begin
        match_j  = valid_reg[way_cnt_reg] && cmp.tag_eq;
        empty_j  = !valid_reg[way_cnt_reg] && !empty_found_reg;
        // first strictly larger rank wins, as long as no empty way was seen
        take_j   = !empty_found_reg && valid_reg[way_cnt_reg] && (!best_set_reg || cmp.rank_gt);
        sel_j    = empty_j || take_j;
        last_j   = (way_cnt_reg == ways_last_reg);
        empty_f  = empty_found_reg || empty_j;
        victim_f = sel_j ? way_cnt_reg : victim_reg;
        vtag_f   = sel_j ? tagrow_reg[way_cnt_reg] : vtag_reg;
        vrank_f  = sel_j ? rank_reg[way_cnt_reg] : vrank_reg;
        vdirty_f = empty_j ? 1'b0 : (take_j ? dirty_reg[way_cnt_reg] : vdirty_reg);
        vbase_c  = (vtag_f << (ob_reg + sb_reg)) | (ADDR_BITS'(set_reg) << ob_reg);
    end

    // ---------------------------------------------------------------- memories
    logic                    line_we, mem_we, meta_we;
    logic [LINE_AW-1:0]      line_addr;
    logic [ADDR_BITS-1:0]    mem_addr;
    logic [SET_W-1:0]        meta_addr;
    logic [7:0]              line_wdata, mem_wdata, line_rdata, mem_rdata;
    logic [ROW_W-1:0]        meta_wdata, meta_rdata;
    logic [OFF_W-1:0]        line_byte;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            meta_wdata[w*META_W +: META_W] = {valid_reg[w], dirty_reg[w], tagrow_reg[w],
                                              rank_reg[w]};
        end
    end

    always_comb begin
        line_we    = 1'b0;
        mem_we     = 1'b0;
        meta_we    = 1'b0;
        line_byte  = byte_cnt_reg;
        line_wdata = mem_rdata;
        mem_addr   = base_reg + ADDR_BITS'(byte_cnt_reg);
        mem_wdata  = line_rdata;
        meta_addr  = set_reg;
        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = '0;
                meta_we   = 1'b1;
                meta_addr = clr_cnt_reg[SET_W-1:0];
            end
            S_WB_WR: begin
                mem_we   = 1'b1;
                mem_addr = vbase_reg + ADDR_BITS'(byte_cnt_reg);
            end
            S_FILL_WR: line_we = 1'b1;
            S_ACC: begin
                line_byte  = off_reg + OFF_W'(acc_cnt_reg);
                line_we    = store_reg && (acc_cnt_reg != nbytes_reg);
                line_wdata = sdata_reg[8*acc_cnt_reg[2:0] +: 8];
            end
            S_ACC_CAP: line_byte = off_reg + OFF_W'(acc_cnt_reg);
            S_META_WR: meta_we = 1'b1;
            default: ;
        endcase
        line_addr = {set_reg, way_reg, line_byte};
    end

    sac_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
        .aclk(aclk), .we(line_we), .addr(line_addr), .wdata(line_wdata), .rdata(line_rdata)
    );

    sac_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_backing_ram (
        .aclk(aclk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
    );

    sac_ram #(.WIDTH(ROW_W), .DEPTH(META_DEPTH)) u_meta_ram (
        .aclk(aclk), .we(meta_we), .addr(meta_addr),
        .wdata(state_reg == S_CLEAR ? '0 : meta_wdata), .rdata(meta_rdata)
    );

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            cfg_ways_reg <= RST_WAYS_IN_USE;
            cfg_ob_reg   <= RST_OFFSET_BITS;
            cfg_sb_reg   <= RST_SET_BITS;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WAYS_IN_USE: cfg_ways_reg <= cfg_wdata[WAYS_CFG_W-1:0];
                    CFG_OFFSET_BITS: cfg_ob_reg   <= cfg_wdata[GEO_CFG_W-1:0];
                    CFG_SET_BITS:    cfg_sb_reg   <= cfg_wdata[GEO_CFG_W-1:0];
                    default: ;
                endcase
            end

            // the result state loads the next word itself when the old one leaves
            if (m_tvalid_reg && m_tready && state_reg != S_RESP) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
                    if (clr_cnt_reg == {ADDR_BITS{1'b1}}) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        store_reg <= (s_tuser == REQ_STORE);
                        addr_reg  <= s_tdata[ADDR_BITS-1:0];
                        size_reg  <= s_tdata[ADDR_BITS +: SIZE_W];
                        sdata_reg <= s_tdata[ADDR_BITS+SIZE_W +: DATA_W];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    ob_reg        <= ob_c;
                    sb_reg        <= sb_c;
                    off_reg       <= off_full_c[OFF_W-1:0];
                    set_reg       <= set_full_c[SET_W-1:0];
                    tag_reg       <= tag_c;
                    blk_last_reg  <= blk_last_c;
                    nbytes_reg    <= nbytes_c;
                    base_reg      <= addr_reg & ~blk_mask_c;
                    ways_last_reg <= WAY_W'(ways_eff_c - WCNT_W'(1));
                    state_reg     <= S_META_RD;
                end
                S_META_RD: state_reg <= S_META_LD;
                S_META_LD: begin
                    for (int w = 0; w < MAX_WAYS; w++) begin
                        valid_reg[w]  <= meta_rdata[w*META_W + META_W - 1];
                        dirty_reg[w]  <= meta_rdata[w*META_W + META_W - 2];
                        tagrow_reg[w] <= meta_rdata[w*META_W + RANK_W +: TAG_W];
                        rank_reg[w]   <= meta_rdata[w*META_W +: RANK_W];
                    end
                    way_cnt_reg     <= '0;
                    empty_found_reg <= 1'b0;
                    best_set_reg    <= 1'b0;
                    hit_reg         <= 1'b0;
                    wb_reg          <= 1'b0;
                    ld_reg          <= '0;
                    state_reg       <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (match_j) begin
                        hit_reg       <= 1'b1;
                        way_reg       <= way_cnt_reg;
                        old_rank_reg  <= rank_reg[way_cnt_reg];
                        was_valid_reg <= 1'b1;
                        way_cnt_reg   <= '0;
                        state_reg     <= S_TOUCH;
                    end else if (last_j) begin
                        // miss: claim the victim, then write back if it is dirty, and fill
                        way_reg              <= victim_f;
                        old_rank_reg         <= vrank_f;
                        was_valid_reg        <= !empty_f;
                        tagrow_reg[victim_f] <= tag_reg;
                        dirty_reg[victim_f]  <= 1'b0;
                        valid_reg[victim_f]  <= 1'b1;
                        vbase_reg            <= vbase_c;
                        byte_cnt_reg         <= '0;
                        if (!empty_f && vdirty_f) begin
                            wb_reg    <= 1'b1;
                            state_reg <= S_WB_RD;
                        end else begin
                            state_reg <= S_FILL_RD;
                        end
                    end else begin
                        if (sel_j) begin
                            victim_reg <= way_cnt_reg;
                            vtag_reg   <= vtag_f;
                            vrank_reg  <= vrank_f;
                            vdirty_reg <= vdirty_f;
                        end
                        if (empty_j) begin
                            empty_found_reg <= 1'b1;
                        end
                        if (take_j) begin
                            best_reg     <= rank_reg[way_cnt_reg];
                            best_set_reg <= 1'b1;
                        end
                        way_cnt_reg <= way_cnt_reg + WAY_W'(1);
                    end
                end
                S_WB_RD: state_reg <= S_WB_WR;
                S_WB_WR: begin
                    if (byte_cnt_reg == blk_last_reg) begin
                        byte_cnt_reg <= '0;
                        state_reg    <= S_FILL_RD;
                    end else begin
                        byte_cnt_reg <= byte_cnt_reg + OFF_W'(1);
                        state_reg    <= S_WB_RD;
                    end
                end
                S_FILL_RD: state_reg <= S_FILL_WR;
                S_FILL_WR: begin
                    if (byte_cnt_reg == blk_last_reg) begin
                        way_cnt_reg <= '0;
                        state_reg   <= S_TOUCH;
                    end else begin
                        byte_cnt_reg <= byte_cnt_reg + OFF_W'(1);
                        state_reg    <= S_FILL_RD;
                    end
                end
                S_TOUCH: begin
                    // age every other valid way that was more recent than the touched one, or all if it was empty
                    if (way_cnt_reg != way_reg && valid_reg[way_cnt_reg] &&
                        (!was_valid_reg || cmp.rank_lt)) begin
                        rank_reg[way_cnt_reg] <= rank_reg[way_cnt_reg] + RANK_W'(1);
                    end
                    if (last_j) begin
                        rank_reg[way_reg] <= '0;
                        acc_cnt_reg       <= '0;
                        state_reg         <= S_ACC;
                    end else begin
                        way_cnt_reg <= way_cnt_reg + WAY_W'(1);
                    end
                end
                S_ACC: begin
                    if (acc_cnt_reg == nbytes_reg) begin
                        if (store_reg) begin
                            dirty_reg[way_reg] <= 1'b1;
                        end
                        state_reg <= S_META_WR;
                    end else if (store_reg) begin
                        acc_cnt_reg <= acc_cnt_reg + NB_W'(1);
                    end else begin
                        state_reg <= S_ACC_CAP;
                    end
                end
                S_ACC_CAP: begin
                    ld_reg[8*acc_cnt_reg[2:0] +: 8] <= line_rdata;
                    acc_cnt_reg <= acc_cnt_reg + NB_W'(1);
                    state_reg   <= S_ACC;
                end
                S_META_WR: state_reg <= S_RESP;
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        // hit in bit 0, load data above it, writeback flag after that
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_DATA_W'({wb_reg, ld_reg, hit_reg});
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/sac_ram.sv =====
// Generic single-port RAM with registered read data.
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/sac_way_cmp.sv =====
// Shared tag and recency-rank comparator used by the way sequencer.
module sac_way_cmp
    import sac_pkg::*;
#(
    parameter int TAG_W  = 16,
    parameter int RANK_W = 3
) (
    input  logic [TAG_W-1:0]  a_tag,
    input  logic [TAG_W-1:0]  b_tag,
    input  logic [RANK_W-1:0] a_rank,
    input  logic [RANK_W-1:0] b_rank,
    output sac_cmp_t          res
);

    always_comb begin
        res.tag_eq  = (a_tag == b_tag);
        res.rank_gt = (a_rank > b_rank);
        res.rank_lt = (a_rank < b_rank);
    end

endmodule

// ===== rtl/core/sac_checker.sv =====
// Port-level checker for the cache, bound to the top level.
module sac_checker
    import sac_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // one word in flight: intake closes right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a word is in flight");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // a writeback only happens on a miss
    a_wb_only_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[OUT_HIT_BIT] && m_tdata[OUT_WB_BIT]))
        else $error("writeback reported on a hit");

    // reset starts the clearing pass: nothing in or out
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("port active right after reset");

endmodule

bind set_assoc_writeback_lru_cache sac_checker u_sac_checker (.*);

// ===== tb/tb_top.sv =====
// Testbench for the set-associative write-back LRU cache: directed and random accesses.
module tb_top;
    import sac_pkg::*;

    localparam int SD_W = 88;          // request word width at default parameters
    localparam int N_SETS = 64;
    localparam int N_WAYS = 8;
    localparam int BLK_MAX = 64;

    // expected outcome of one access
    typedef struct {
        logic        hit;
        logic [63:0] load_data;
        logic        wrote_back;
    } access_result_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [SD_W-1:0] s_tdata = '0;    // address, access_size, store_data, zero pad
    logic            s_tuser = 1'b0;  // req_type
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;     // hit, load_data, wrote_back, zero pad

    always #2 aclk = ~aclk;

    set_assoc_writeback_lru_cache dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // ---------------------------------------------------------------
    // Cache shadow: line state, block bytes and backing memory
    // ---------------------------------------------------------------
    logic        sh_valid [N_SETS][N_WAYS];
    logic        sh_dirty [N_SETS][N_WAYS];
    int unsigned sh_tag   [N_SETS][N_WAYS];
    int unsigned sh_rank  [N_SETS][N_WAYS];
    logic [7:0]  sh_bytes [N_SETS][N_WAYS][BLK_MAX];
    logic [7:0]  sh_mem   [65536];
    logic [3:0]  reg_ways;
    logic [2:0]  reg_offset;
    logic [2:0]  reg_sets;

    access_result_t pending_results[$];
    int  errors = 0;
    bit  hold_request = 1'b0;   // asks the result side for one long stall

    // LRU rank update: way becomes most recent, younger ways (all valid ones if it was empty) age by one
    function automatic void promote_way(int unsigned set, int unsigned way,
                                        int unsigned ways, bit was_valid);
        int unsigned old;
        old = sh_rank[set][way];
        for (int j = 0; j < ways; j++) begin
            if (j != way && sh_valid[set][j]) begin
                if ((!was_valid || sh_rank[set][j] < old) && sh_rank[set][j] < 255)
                    sh_rank[set][j]++;
            end
        end
        sh_rank[set][way] = 0;
    endfunction

    function automatic access_result_t predict_access(bit is_store, logic [15:0] addr,
                                                      logic [3:0] size_in, logic [63:0] wdata);
        access_result_t r;
        int unsigned ways, ob, sb, blk, set, tag, off, way, size, vbase, best;
        bit found_empty;
        r.hit = 1'b0;
        r.load_data = '0;
        r.wrote_back = 1'b0;
        ways = reg_ways;
        ob = reg_offset;
        sb = reg_sets;
        way = 0;
        if (ways == 0) ways = 1;
        if (ways > N_WAYS) ways = N_WAYS;
        while (ob > 0 && (1 << ob) > BLK_MAX) ob--;
        while (sb > 0 && ((1 << sb) > N_SETS || ob + sb > 16)) sb--;
        blk = 1 << ob;
        off = addr & (blk - 1);
        set = (addr >> ob) & ((1 << sb) - 1);
        tag = addr >> (ob + sb);
        size = size_in;
        if (size > 8) size = 8;
        if (off + size > blk) size = blk - off;

        for (int i = 0; i < ways; i++) begin
            if (!r.hit && sh_valid[set][i] && sh_tag[set][i] == tag) begin
                r.hit = 1'b1;
                way = i;
            end
        end
        if (r.hit) begin
            promote_way(set, way, ways, 1'b1);
        end else begin
            found_empty = 1'b0;
            best = 0;
            for (int i = 0; i < ways; i++) begin
                if (!found_empty) begin
                    if (!sh_valid[set][i]) begin
                        way = i;
                        found_empty = 1'b1;
                    end else if (i == 0 || sh_rank[set][i] > best) begin
                        best = sh_rank[set][i];
                        way = i;
                    end
                end
            end
            if (!found_empty && sh_dirty[set][way]) begin
                vbase = ((sh_tag[set][way] << (ob + sb)) | (set << ob)) & 16'hFFFF;
                for (int i = 0; i < blk; i++)
                    sh_mem[(vbase + i) & 16'hFFFF] = sh_bytes[set][way][i];
                r.wrote_back = 1'b1;
            end
            for (int i = 0; i < blk; i++)
                sh_bytes[set][way][i] = sh_mem[((addr & ~(blk - 1)) + i) & 16'hFFFF];
            sh_tag[set][way] = tag;
            sh_dirty[set][way] = 1'b0;
            promote_way(set, way, ways, !found_empty);
            sh_valid[set][way] = 1'b1;
        end
        if (is_store) begin
            for (int i = 0; i < size; i++)
                sh_bytes[set][way][off + i] = wdata[8*i +: 8];
            sh_dirty[set][way] = 1'b1;
        end else begin
            for (int i = 0; i < size; i++)
                r.load_data[8*i +: 8] = sh_bytes[set][way][off + i];
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------
    // Sender: one request word, expectation queued on acceptance
    // ---------------------------------------------------------------
    task automatic send_access(bit is_store, logic [15:0] addr, logic [3:0] size,
                               logic [63:0] wdata);
        int gap;
        gap = idle_cycles();
        repeat (gap) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = is_store;
        s_tdata  = {4'b0, wdata, size, addr};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_access(is_store, addr, size, wdata));
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // block is idle only once all results are back and it is ready again
    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [3:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_WAYS_IN_USE: reg_ways = value;
            CFG_OFFSET_BITS: reg_offset = value[2:0];
            CFG_SET_BITS:    reg_sets = value[2:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [3:0] ways, logic [3:0] obits, logic [3:0] sbits);
        wait_drained();
        write_reg(CFG_WAYS_IN_USE, ways);
        write_reg(CFG_OFFSET_BITS, obits);
        write_reg(CFG_SET_BITS, sbits);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Block size only ever shrinks after traffic starts, so no line byte is read
    // before a fill wrote it. Offset 7 clamps to the 64-byte maximum.
    task automatic test_edges();
        set_geometry(4'd15, 4'd7, 4'd7);
        send_access(1'b0, 16'h0000, 4'd0, '0);            // size zero, miss
        send_access(1'b0, 16'hFFFF, 4'd8, '0);            // top address, cut at block end
        send_access(1'b1, 16'h0008, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(1'b0, 16'h0008, 4'd15, '0);           // oversized size clamps to 8
        send_access(1'b1, 16'hFFFC, 4'd8, 64'h0123_4567_89AB_CDEF); // crosses block end
        send_access(1'b0, 16'hFFF8, 4'd8, '0);
        send_access(1'b1, 16'h003F, 4'd1, 64'hA5);        // last byte of a block
        send_access(1'b0, 16'h0038, 4'd8, '0);
        send_access(1'b1, 16'h1234, 4'd0, rand_word());   // store of no bytes still dirties
    endtask

    // one way, one set: every new tag evicts, dirty victims go back to memory
    task automatic test_writeback();
        set_geometry(4'd0, 4'd6, 4'd0);
        send_access(1'b1, 16'h0000, 4'd8, 64'h1111_2222_3333_4444);
        send_access(1'b1, 16'h1000, 4'd4, 64'hDEAD_BEEF);
        send_access(1'b0, 16'h0000, 4'd8, '0);
        send_access(1'b0, 16'h1000, 4'd4, '0);
        send_access(1'b0, 16'h0000, 4'd8, '0);
        set_geometry(4'd2, 4'd6, 4'd0);                   // two-way LRU order
        send_access(1'b1, 16'h2000, 4'd2, 64'hBEEF);
        send_access(1'b0, 16'h0000, 4'd1, '0);
        send_access(1'b0, 16'h3000, 4'd1, '0);            // evicts the dirty 0x2000 line
        send_access(1'b0, 16'h2000, 4'd2, '0);
    endtask

    task automatic run_random(int count);
        logic [15:0] addr;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 85)
                addr = 16'($urandom_range(0, 7) * 16'h1040 + $urandom_range(0, 255));
            else
                addr = 16'($urandom());
            send_access(1'($urandom_range(0, 1)), addr, 4'($urandom_range(0, 15)),
                        rand_word());
        end
    endtask

    task automatic test_random_phases();
        set_geometry(4'd8, 4'd6, 4'd6);
        run_random(70);
        set_geometry(4'd3, 4'd5, 4'd0);
        hold_request = 1'b1;        // result side stalls, input backs up
        run_random(70);
        set_geometry(4'd0, 4'd4, 4'd2);
        run_random(70);
        set_geometry(4'd15, 4'd3, 4'd3);
        run_random(70);
        set_geometry(4'd2, 4'd0, 4'd7);
        run_random(70);
        set_geometry(4'd8, 4'd0, 4'd1);
        run_random(80);
    endtask

    // ---------------------------------------------------------------
    // Result side: random backpressure plus one long hold-off
    // ---------------------------------------------------------------
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready = 1'b0;
                for (int c = 0; c < 3000; c++) @(negedge aclk);
                hold_request = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? idle_cycles() : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge aclk) begin
        access_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[OUT_HIT_BIT] !== exp_r.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, exp_r.hit,
                             m_tdata[OUT_HIT_BIT]);
                    errors++;
                end
                if (m_tdata[OUT_LOAD_LSB +: 64] !== exp_r.load_data) begin
                    $display("%0t: load_data expected %h actual %h", $time, exp_r.load_data,
                             m_tdata[OUT_LOAD_LSB +: 64]);
                    errors++;
                end
                if (m_tdata[OUT_WB_BIT] !== exp_r.wrote_back) begin
                    $display("%0t: wrote_back expected %b actual %b", $time,
                             exp_r.wrote_back, m_tdata[OUT_WB_BIT]);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        foreach (sh_valid[s, w]) begin
            sh_valid[s][w] = 1'b0;
            sh_dirty[s][w] = 1'b0;
            sh_tag[s][w] = 0;
            sh_rank[s][w] = 0;
        end
        foreach (sh_mem[a]) sh_mem[a] = 8'h00;
        reg_ways = RST_WAYS_IN_USE;
        reg_offset = RST_OFFSET_BITS;
        reg_sets = RST_SET_BITS;

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        // clearing pass runs until s_tready rises
        test_edges();
        test_writeback();
        test_random_phases();

        wait_drained();
        repeat (400) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #12000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
